>>> rtl/core/atmc_pkg.sv
package atmc_pkg;

    localparam int ROWS_DEFAULT = 25;
    localparam int COLS_DEFAULT = 80;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_J     = 8'h4a;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_7     = 8'h37;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [2:0] ESC_IDLE  = 3'd0;
    localparam logic [2:0] ESC_SEEN  = 3'd1;
    localparam logic [2:0] ESC_BRK   = 3'd2;
    localparam logic [2:0] ESC_DIGIT = 3'd3;
    localparam logic [2:0] ESC_COLOR = 3'd4;

    localparam logic [7:0] COLOR_RESET   = 8'h07;
    localparam logic [7:0] COLOR_BRIGHT  = 8'h0f;
    localparam logic [7:0] COLOR_INVERSE = 8'h70;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [10:0] cursor_cell;
        logic [7:0]  current_color;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_READ_WAIT,
        ST_FILL,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_ZERO_ROW,
        ST_OUT
    } state_t;

    // Datapath operations selected by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECODE,
        OP_READ,
        OP_CLEAR_STEP,
        OP_FILL_STEP,
        OP_SCROLL_RD,
        OP_SCROLL_WR,
        OP_ZERO_STEP,
        OP_PRESENT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   start_sweep;
    } atmc_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic need_fill;
        logic need_scroll;
        logic is_read;
    } atmc_status_t;

    function automatic logic [3:0] palette(input logic [2:0] idx);
        logic [3:0] r;
        begin
            case (idx)
                3'd0: r = 4'd0;
                3'd1: r = 4'd4;
                3'd2: r = 4'd2;
                3'd3: r = 4'd14;
                3'd4: r = 4'd1;
                3'd5: r = 4'd5;
                3'd6: r = 4'd3;
                3'd7: r = 4'd15;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/core/ansi_text_mode_console.sv
// ANSI text-mode console over a ROWS x COLS screen of 16-bit cells
// (attribute high byte, character low byte). After reset the screen memory
// is zeroed, one cell a cycle, before the first transaction is taken. A put
// is decoded and its result then offered; a read also passes through the
// registered memory read and the result register before it is offered. The
// next transaction is taken only after the result handshake. Clear screen
// (ESC [2J) fills every cell with a space in the current colour; a scroll
// copies each row up, a read and a write per cell, then zeroes the bottom
// row. The memory is walked one cell at a time. One transaction is in flight
// at a time.
module ansi_text_mode_console #(
    parameter int ROWS = atmc_pkg::ROWS_DEFAULT,
    parameter int COLS = atmc_pkg::COLS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  atmc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output atmc_pkg::out_item_t out_data
);

    atmc_pkg::atmc_cmd_t    cmd;
    atmc_pkg::atmc_status_t status;

    atmc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    atmc_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_data)
    );

    // results are offered only while no new transaction can be accepted
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output handshakes overlap");

    // a result follows every accepted transaction before the next acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while busy");

    // cursor stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.cursor_cell) < ROWS * COLS))
        else $error("cursor off screen");

endmodule

>>> rtl/core/atmc_ctrl.sv
module atmc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  atmc_pkg::atmc_status_t status,
    output atmc_pkg::atmc_cmd_t    cmd
);

    atmc_pkg::state_t state_reg;
    atmc_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atmc_pkg::ST_CLEAR_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = atmc_pkg::OP_NONE;
        cmd.start_sweep = 1'b0;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        case (state_reg)
            atmc_pkg::ST_CLEAR_INIT:
            begin
                cmd.op = atmc_pkg::OP_CLEAR_STEP;
                if (status.sweep_last)
                begin
                    state_next = atmc_pkg::ST_IDLE;
                end
            end
            atmc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = atmc_pkg::OP_LOAD;
                    state_next = atmc_pkg::ST_DECODE;
                end
            end
            atmc_pkg::ST_DECODE:
            begin
                cmd.op = atmc_pkg::OP_DECODE;
                if (status.is_read)
                begin
                    cmd.op     = atmc_pkg::OP_READ;
                    state_next = atmc_pkg::ST_READ_WAIT;
                end
                else if (status.need_fill)
                begin
                    cmd.start_sweep = 1'b1;
                    state_next      = atmc_pkg::ST_FILL;
                end
                else if (status.need_scroll)
                begin
                    cmd.start_sweep = 1'b1;
                    state_next      = atmc_pkg::ST_SCROLL_RD;
                end
                else
                begin
                    state_next = atmc_pkg::ST_OUT;
                end
            end
            atmc_pkg::ST_READ_WAIT:
            begin
                cmd.op     = atmc_pkg::OP_PRESENT;
                state_next = atmc_pkg::ST_OUT;
            end
            atmc_pkg::ST_FILL:
            begin
                cmd.op = atmc_pkg::OP_FILL_STEP;
                if (status.sweep_last)
                begin
                    state_next = atmc_pkg::ST_OUT;
                end
            end
            atmc_pkg::ST_SCROLL_RD:
            begin
                cmd.op     = atmc_pkg::OP_SCROLL_RD;
                state_next = atmc_pkg::ST_SCROLL_WR;
            end
            atmc_pkg::ST_SCROLL_WR:
            begin
                cmd.op = atmc_pkg::OP_SCROLL_WR;
                if (status.sweep_last)
                begin
                    cmd.start_sweep = 1'b1;
                    state_next      = atmc_pkg::ST_ZERO_ROW;
                end
                else
                begin
                    state_next = atmc_pkg::ST_SCROLL_RD;
                end
            end
            atmc_pkg::ST_ZERO_ROW:
            begin
                cmd.op = atmc_pkg::OP_ZERO_STEP;
                if (status.sweep_last)
                begin
                    state_next = atmc_pkg::ST_OUT;
                end
            end
            atmc_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = atmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = atmc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/atmc_dp.sv
module atmc_dp #(
    parameter int ROWS = atmc_pkg::ROWS_DEFAULT,
    parameter int COLS = atmc_pkg::COLS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  atmc_pkg::in_item_t     in_item,
    input  atmc_pkg::atmc_cmd_t    cmd,
    output atmc_pkg::atmc_status_t status,
    output atmc_pkg::out_item_t    out_item
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLS);

    logic [15:0] mem [CELLS];

    atmc_pkg::in_item_t item_reg;
    logic [2:0]  phase_reg;
    logic [7:0]  digit_reg;
    logic [3:0]  pend_reg;
    logic [7:0]  color_reg;
    logic [10:0] cursor_reg;
    logic [CW-1:0] col_reg;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_end_reg;
    logic [15:0] rdata_reg;
    logic [15:0] data_reg;

    // decode result (combinational from held item and state)
    logic [2:0]  phase_next;
    logic [7:0]  digit_next;
    logic [3:0]  pend_next;
    logic [7:0]  color_next;
    logic [11:0] cur_w;
    logic [CW-1:0] col_next;
    logic        wr_en;
    logic        consumed;
    logic        fill_next;
    logic        scroll_next;
    logic [7:0]  ch;

    assign ch = item_reg.char_code;

    // escape parser and cursor update for one put byte
    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        pend_next  = pend_reg;
        color_next = color_reg;
        cur_w      = {1'b0, cursor_reg};
        col_next   = col_reg;
        wr_en      = 1'b0;
        consumed   = 1'b0;
        fill_next  = 1'b0;
        scroll_next = 1'b0;
        case (phase_reg)
            atmc_pkg::ESC_SEEN:
            begin
                if (ch == atmc_pkg::CH_LBRK)
                begin
                    phase_next = atmc_pkg::ESC_BRK;
                    consumed   = 1'b1;
                end
            end
            atmc_pkg::ESC_BRK:
            begin
                if (ch == atmc_pkg::CH_0 || ch == atmc_pkg::CH_1 ||
                    ch == atmc_pkg::CH_2 || ch == atmc_pkg::CH_3 ||
                    ch == atmc_pkg::CH_4 || ch == atmc_pkg::CH_7)
                begin
                    digit_next = ch;
                    phase_next = atmc_pkg::ESC_DIGIT;
                    consumed   = 1'b1;
                end
            end
            atmc_pkg::ESC_DIGIT:
            begin
                if (ch >= atmc_pkg::CH_0 && ch <= atmc_pkg::CH_7)
                begin
                    if (digit_reg == atmc_pkg::CH_3 || digit_reg == atmc_pkg::CH_4)
                    begin
                        pend_next  = atmc_pkg::palette(ch[2:0]);
                        phase_next = atmc_pkg::ESC_COLOR;
                        consumed   = 1'b1;
                    end
                end
                else if (ch == atmc_pkg::CH_J)
                begin
                    if (digit_reg == atmc_pkg::CH_2)
                    begin
                        fill_next  = 1'b1;
                        cur_w      = '0;
                        col_next   = '0;
                        phase_next = atmc_pkg::ESC_IDLE;
                        consumed   = 1'b1;
                    end
                end
                else if (ch == atmc_pkg::CH_M)
                begin
                    if (digit_reg == atmc_pkg::CH_0)
                    begin
                        color_next = atmc_pkg::COLOR_RESET;
                        phase_next = atmc_pkg::ESC_IDLE;
                        consumed   = 1'b1;
                    end
                    else if (digit_reg == atmc_pkg::CH_1)
                    begin
                        color_next = atmc_pkg::COLOR_BRIGHT;
                        phase_next = atmc_pkg::ESC_IDLE;
                        consumed   = 1'b1;
                    end
                    else if (digit_reg == atmc_pkg::CH_7)
                    begin
                        color_next = atmc_pkg::COLOR_INVERSE;
                        phase_next = atmc_pkg::ESC_IDLE;
                        consumed   = 1'b1;
                    end
                end
            end
            atmc_pkg::ESC_COLOR:
            begin
                if (ch == atmc_pkg::CH_M && digit_reg == atmc_pkg::CH_3)
                begin
                    color_next = {color_reg[7:4], pend_reg};
                    phase_next = atmc_pkg::ESC_IDLE;
                    consumed   = 1'b1;
                end
                else if (ch == atmc_pkg::CH_M && digit_reg == atmc_pkg::CH_4)
                begin
                    color_next = {pend_reg, color_reg[3:0]};
                    phase_next = atmc_pkg::ESC_IDLE;
                    consumed   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // ordinary byte handling; column tracked alongside the cursor
        if (!consumed)
        begin
            phase_next = atmc_pkg::ESC_IDLE;
            if (ch == atmc_pkg::CH_ESC)
            begin
                phase_next = atmc_pkg::ESC_SEEN;
            end
            else
            begin
                if (ch == atmc_pkg::CH_CR)
                begin
                    cur_w    = {1'b0, cursor_reg} - 12'(col_reg);
                    col_next = '0;
                end
                else if (ch == atmc_pkg::CH_LF)
                begin
                    cur_w    = {1'b0, cursor_reg} + 12'(COLS) - 12'(col_reg);
                    col_next = '0;
                end
                else if (ch == atmc_pkg::CH_TAB)
                begin
                    cur_w = {1'b0, cursor_reg} + 12'd4 - 12'(cursor_reg[1:0]);
                    if (32'(col_reg) + 4 - 32'(cursor_reg[1:0]) >= COLS)
                    begin
                        col_next = CW'(32'(col_reg) + 4 - 32'(cursor_reg[1:0]) - COLS);
                    end
                    else
                    begin
                        col_next = CW'(32'(col_reg) + 4 - 32'(cursor_reg[1:0]));
                    end
                end
                else if (ch == atmc_pkg::CH_BS)
                begin
                    if (cursor_reg != '0)
                    begin
                        cur_w = {1'b0, cursor_reg} - 12'd1;
                        if (col_reg == '0)
                        begin
                            col_next = CW'(COLS - 1);
                        end
                        else
                        begin
                            col_next = col_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    wr_en = (32'(cursor_reg) < CELLS);
                    cur_w = {1'b0, cursor_reg} + 12'd1;
                    if (32'(col_reg) == COLS - 1)
                    begin
                        col_next = '0;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                if (32'(cur_w) >= CELLS)
                begin
                    scroll_next = 1'b1;
                    cur_w       = cur_w - 12'(COLS);
                end
            end
        end
    end

    assign status.is_read     = (item_reg.cmd == atmc_pkg::CMD_READ);
    assign status.need_fill   = fill_next;
    assign status.need_scroll = scroll_next;
    assign status.sweep_last  = (sweep_reg == sweep_end_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= atmc_pkg::ESC_IDLE;
            digit_reg     <= '0;
            pend_reg      <= '0;
            color_reg     <= atmc_pkg::COLOR_RESET;
            cursor_reg    <= 11'(COLS * (ROWS - 1));
            col_reg       <= '0;
            sweep_reg     <= '0;
            sweep_end_reg <= AW'(CELLS - 1);
        end
        else
        begin
            case (cmd.op)
                atmc_pkg::OP_DECODE:
                begin
                    if (!status.is_read)
                    begin
                        phase_reg  <= phase_next;
                        digit_reg  <= digit_next;
                        pend_reg   <= pend_next;
                        color_reg  <= color_next;
                        cursor_reg <= cur_w[10:0];
                        col_reg    <= col_next;
                    end
                end
                atmc_pkg::OP_CLEAR_STEP,
                atmc_pkg::OP_FILL_STEP,
                atmc_pkg::OP_SCROLL_WR,
                atmc_pkg::OP_ZERO_STEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
            // sweep start and last address: row copy ends before the bottom row
            if (cmd.start_sweep)
            begin
                sweep_reg <= (cmd.op == atmc_pkg::OP_SCROLL_WR) ?
                             AW'(CELLS - COLS) : '0;
                sweep_end_reg <= (cmd.op == atmc_pkg::OP_DECODE && scroll_next) ?
                                 AW'(CELLS - COLS - 1) : AW'(CELLS - 1);
            end
        end
    end

    // screen memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            atmc_pkg::OP_CLEAR_STEP, atmc_pkg::OP_ZERO_STEP:
            begin
                mem[sweep_reg] <= '0;
            end
            atmc_pkg::OP_FILL_STEP:
            begin
                mem[sweep_reg] <= {color_reg, atmc_pkg::CH_SPACE};
            end
            atmc_pkg::OP_DECODE:
            begin
                if (!status.is_read && wr_en)
                begin
                    mem[cursor_reg[AW-1:0]] <= {color_reg, ch};
                end
            end
            atmc_pkg::OP_SCROLL_WR:
            begin
                mem[sweep_reg] <= rdata_reg;
            end
            default:
            begin
            end
        endcase
        case (cmd.op)
            atmc_pkg::OP_READ:
            begin
                rdata_reg <= mem[item_reg.cell_index[AW-1:0]];
            end
            atmc_pkg::OP_SCROLL_RD:
            begin
                rdata_reg <= mem[AW'(32'(sweep_reg) + COLS)];
            end
            default:
            begin
            end
        endcase
    end

    // item capture and result data
    always_ff @(posedge clk)
    begin
        if (cmd.op == atmc_pkg::OP_LOAD)
        begin
            item_reg <= in_item;
            data_reg <= '0;
        end
        if (cmd.op == atmc_pkg::OP_PRESENT)
        begin
            data_reg <= (32'(item_reg.cell_index) < CELLS) ? rdata_reg : '0;
        end
    end

    assign out_item.cell_data     = data_reg;
    assign out_item.cursor_cell   = cursor_reg;
    assign out_item.current_color = color_reg;

endmodule

>>> sim/tb_ansi_text_mode_console.sv
`timescale 1ns / 100ps

module tb_ansi_text_mode_console;

    localparam int ROWS  = atmc_pkg::ROWS_DEFAULT;
    localparam int COLS  = atmc_pkg::COLS_DEFAULT;
    localparam int CELLS = ROWS * COLS;
    localparam int SCROLL_CYCLES = 2 * COLS * (ROWS - 1) + COLS;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    atmc_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    atmc_pkg::out_item_t out_data;

    // console shadow state
    logic [2:0]  esc_phase;
    logic [7:0]  esc_digit;
    logic [3:0]  esc_color;
    logic [7:0]  attr;
    int unsigned cursor;
    logic [15:0] screen [CELLS];

    atmc_pkg::out_item_t expected_q[$];
    int        mismatches = 0;
    int        unexpected = 0;
    longint    cycles = 0;
    bit        sink_busy_allowed = 1'b1;

    ansi_text_mode_console uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #1 clk = ~clk;

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [3:0] ansi_color(input logic [2:0] idx);
        logic [3:0] table_v [8];
        table_v = '{4'd0, 4'd4, 4'd2, 4'd14, 4'd1, 4'd5, 4'd3, 4'd15};
        return table_v[idx];
    endfunction

    task automatic shadow_reset();
        esc_phase = atmc_pkg::ESC_IDLE;
        esc_digit = '0;
        esc_color = '0;
        attr      = atmc_pkg::COLOR_RESET;
        cursor    = COLS * (ROWS - 1);
        foreach (screen[i]) screen[i] = '0;
    endtask

    // returns 1 when the escape parser swallowed the byte
    function automatic bit escape_consume(input logic [7:0] ch);
        case (esc_phase)
            atmc_pkg::ESC_SEEN:
            begin
                if (ch == atmc_pkg::CH_LBRK)
                begin
                    esc_phase = atmc_pkg::ESC_BRK;
                    return 1;
                end
            end
            atmc_pkg::ESC_BRK:
            begin
                if (ch == atmc_pkg::CH_0 || ch == atmc_pkg::CH_1 ||
                    ch == atmc_pkg::CH_2 || ch == atmc_pkg::CH_3 ||
                    ch == atmc_pkg::CH_4 || ch == atmc_pkg::CH_7)
                begin
                    esc_digit = ch;
                    esc_phase = atmc_pkg::ESC_DIGIT;
                    return 1;
                end
            end
            atmc_pkg::ESC_DIGIT:
            begin
                if (ch >= atmc_pkg::CH_0 && ch <= atmc_pkg::CH_7)
                begin
                    if (esc_digit == atmc_pkg::CH_3 || esc_digit == atmc_pkg::CH_4)
                    begin
                        esc_color = ansi_color(3'(ch - atmc_pkg::CH_0));
                        esc_phase = atmc_pkg::ESC_COLOR;
                        return 1;
                    end
                end
                else if (ch == atmc_pkg::CH_J)
                begin
                    if (esc_digit == atmc_pkg::CH_2)
                    begin
                        foreach (screen[i]) screen[i] = {attr, atmc_pkg::CH_SPACE};
                        cursor = 0;
                        esc_phase = atmc_pkg::ESC_IDLE;
                        return 1;
                    end
                end
                else if (ch == atmc_pkg::CH_M)
                begin
                    if (esc_digit == atmc_pkg::CH_0 || esc_digit == atmc_pkg::CH_1 ||
                        esc_digit == atmc_pkg::CH_7)
                    begin
                        attr = (esc_digit == atmc_pkg::CH_0) ? atmc_pkg::COLOR_RESET :
                               (esc_digit == atmc_pkg::CH_1) ? atmc_pkg::COLOR_BRIGHT :
                               atmc_pkg::COLOR_INVERSE;
                        esc_phase = atmc_pkg::ESC_IDLE;
                        return 1;
                    end
                end
            end
            atmc_pkg::ESC_COLOR:
            begin
                if (ch == atmc_pkg::CH_M && esc_digit == atmc_pkg::CH_3)
                begin
                    attr = {attr[7:4], esc_color};
                    esc_phase = atmc_pkg::ESC_IDLE;
                    return 1;
                end
                else if (ch == atmc_pkg::CH_M && esc_digit == atmc_pkg::CH_4)
                begin
                    attr = {esc_color, attr[3:0]};
                    esc_phase = atmc_pkg::ESC_IDLE;
                    return 1;
                end
            end
            default:
            begin
            end
        endcase
        return 0;
    endfunction

    function automatic void console_put(input logic [7:0] ch);
        if (escape_consume(ch))
            return;
        if (ch == atmc_pkg::CH_ESC)
        begin
            esc_phase = atmc_pkg::ESC_SEEN;
            return;
        end
        case (ch)
            atmc_pkg::CH_CR:  cursor = cursor - cursor % COLS;
            atmc_pkg::CH_LF:  cursor = cursor + COLS - cursor % COLS;
            atmc_pkg::CH_TAB: cursor = cursor + 4 - cursor % 4;
            atmc_pkg::CH_BS:  if (cursor > 0) cursor = cursor - 1;
            default:
            begin
                if (cursor < CELLS)
                    screen[cursor] = {attr, ch};
                cursor = cursor + 1;
            end
        endcase
        esc_phase = atmc_pkg::ESC_IDLE;
        if (cursor / COLS >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen[i] = '0;
            cursor = cursor - COLS;
        end
    endfunction

    function automatic atmc_pkg::out_item_t console_result(input atmc_pkg::in_item_t it);
        atmc_pkg::out_item_t r;
        r.cell_data = '0;
        if (it.cmd == atmc_pkg::CMD_PUT)
            console_put(it.char_code);
        else if (it.cell_index < CELLS)
            r.cell_data = screen[it.cell_index];
        r.cursor_cell   = 11'(cursor);
        r.current_color = attr;
        return r;
    endfunction

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // send one transaction and record its expected result
    task automatic send_item(input atmc_pkg::in_item_t it);
        int gap;
        gap = gap_length();
        // valid was dropped at the previous acceptance edge
        @(posedge clk);
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        expected_q.push_back(console_result(it));
        // ready is sampled mid-cycle, acceptance is the following edge
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic put_char(input logic [7:0] ch);
        atmc_pkg::in_item_t it;
        it = '{cmd: atmc_pkg::CMD_PUT, char_code: ch, cell_index: 11'($urandom)};
        send_item(it);
    endtask

    task automatic read_cell(input logic [10:0] idx);
        atmc_pkg::in_item_t it;
        it = '{cmd: atmc_pkg::CMD_READ, char_code: 8'($urandom), cell_index: idx};
        send_item(it);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    // receiver backpressure
    initial
    begin
        int stall;
        forever
        begin
            @(posedge clk);
            stall = gap_length();
            if (stall != 0 && sink_busy_allowed)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        atmc_pkg::out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (out_data.cell_data !== exp_r.cell_data ||
                    out_data.cursor_cell !== exp_r.cursor_cell ||
                    out_data.current_color !== exp_r.current_color)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp data %h cur %0d col %h,",
                                  " got data %h cur %0d col %h"},
                                 exp_r.cell_data, exp_r.cursor_cell, exp_r.current_color,
                                 out_data.cell_data, out_data.cursor_cell,
                                 out_data.current_color);
                end
            end
        end
    end

    task automatic test_reset_state();
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        read_cell(11'd2047);
    endtask

    task automatic test_text_and_controls();
        put_char(8'h41);
        put_char(8'hff);
        put_char(8'h00);
        put_char(atmc_pkg::CH_TAB);
        put_char(atmc_pkg::CH_BS);
        put_char(atmc_pkg::CH_CR);
        read_cell(11'(COLS * (ROWS - 1)));
        read_cell(11'(COLS * (ROWS - 1) + 1));
        put_char(atmc_pkg::CH_LF);   // scroll
        read_cell(11'(COLS * (ROWS - 2)));
    endtask

    task automatic test_escapes();
        logic [7:0] seq[$];
        seq = '{atmc_pkg::CH_ESC, atmc_pkg::CH_LBRK, atmc_pkg::CH_3, atmc_pkg::CH_2,
                atmc_pkg::CH_M, atmc_pkg::CH_ESC, atmc_pkg::CH_LBRK, atmc_pkg::CH_4,
                atmc_pkg::CH_7, atmc_pkg::CH_M, 8'h58, atmc_pkg::CH_ESC,
                atmc_pkg::CH_LBRK, atmc_pkg::CH_1, atmc_pkg::CH_M, atmc_pkg::CH_ESC,
                atmc_pkg::CH_LBRK, atmc_pkg::CH_7, atmc_pkg::CH_M, atmc_pkg::CH_ESC,
                atmc_pkg::CH_LBRK, atmc_pkg::CH_2, atmc_pkg::CH_J, atmc_pkg::CH_BS,
                atmc_pkg::CH_BS, atmc_pkg::CH_ESC, atmc_pkg::CH_ESC, atmc_pkg::CH_LBRK,
                atmc_pkg::CH_0, atmc_pkg::CH_M, atmc_pkg::CH_ESC, 8'h51,
                atmc_pkg::CH_ESC, atmc_pkg::CH_LBRK, 8'h39, atmc_pkg::CH_M};
        foreach (seq[i]) put_char(seq[i]);
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
    endtask

    task automatic random_escape();
        logic [7:0] d;
        int k;
        k = $urandom_range(0, 9);
        put_char(atmc_pkg::CH_ESC);
        if (k == 0)
        begin
            put_char(8'($urandom));
            return;
        end
        put_char(atmc_pkg::CH_LBRK);
        d = (k < 4) ? atmc_pkg::CH_3 : (k < 7) ? atmc_pkg::CH_4 :
            (k == 7) ? atmc_pkg::CH_0 : (k == 8) ? atmc_pkg::CH_1 : atmc_pkg::CH_7;
        if ($urandom_range(0, 30) == 0) d = atmc_pkg::CH_2;
        put_char(d);
        if (d == atmc_pkg::CH_2)
            put_char(atmc_pkg::CH_J);
        else if (d == atmc_pkg::CH_3 || d == atmc_pkg::CH_4)
        begin
            put_char(8'(atmc_pkg::CH_0 + $urandom_range(0, 7)));
            put_char($urandom_range(0, 9) == 0 ? 8'($urandom) : atmc_pkg::CH_M);
        end
        else
            put_char($urandom_range(0, 9) == 0 ? 8'($urandom) : atmc_pkg::CH_M);
    endtask

    task automatic test_random(input int count);
        int sent;
        int p;
        bit drained;
        sent = 0;
        drained = 1'b0;
        while (sent < count)
        begin
            p = $urandom_range(0, 99);
            if (p < 30)
                read_cell($urandom_range(0, 9) == 0 ? 11'($urandom) :
                          11'($urandom_range(0, CELLS - 1)));
            else if (p < 45)
            begin
                random_escape();
                sent += 3;
            end
            else if (p < 55)
            begin
                case ($urandom_range(0, 3))
                    0: put_char(atmc_pkg::CH_CR);
                    1: put_char(atmc_pkg::CH_LF);
                    2: put_char(atmc_pkg::CH_TAB);
                    default: put_char(atmc_pkg::CH_BS);
                endcase
            end
            else if (p < 85)
                put_char(8'($urandom_range(8'h20, 8'h7e)));
            else
                put_char(8'($urandom));
            sent++;
            if (!drained && sent >= count / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    task automatic test_no_backpressure();
        sink_busy_allowed = 1'b0;
        repeat (20) put_char(8'($urandom_range(8'h20, 8'h7e)));
        wait_drained();
        sink_busy_allowed = 1'b1;
    endtask

    initial
    begin
        shadow_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_text_and_controls();
        test_escapes();
        test_random(1050);
        test_no_backpressure();
        wait_drained();
        repeat (SCROLL_CYCLES + CELLS + 100) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
rtl/core/atmc_pkg.sv
rtl/core/atmc_ctrl.sv
rtl/core/atmc_dp.sv
rtl/core/ansi_text_mode_console.sv
sim/tb_ansi_text_mode_console.sv
